@@ sv/quantized_code_bit_packer_assert.svh @@
// Assertion macros for the quantized code bit packer checker.
// Needs signals clk and rst_n in the scope of each use.
`ifndef QUANTIZED_CODE_BIT_PACKER_ASSERT_SVH
`define QUANTIZED_CODE_BIT_PACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define QCBP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define QCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/qcbp_pkg.sv @@
// Shared types, constants and layout functions of the quantized code bit packer.
// Used by the top level and the code memory; depends on nothing.
package qcbp_pkg;

    localparam int GroupSize = 64;
    localparam int AddrW     = 6;
    localparam int CodeW     = 7;

    // Code width settings
    localparam logic [2:0] CW_2 = 3'd2;
    localparam logic [2:0] CW_3 = 3'd3;
    localparam logic [2:0] CW_4 = 3'd4;
    localparam logic [2:0] CW_5 = 3'd5;
    localparam logic [2:0] CW_6 = 3'd6;
    localparam logic [2:0] CW_7 = 3'd7;

    localparam logic [2:0] CW_RESET = CW_4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST
    } state_t;

    // One read step of a packed byte: which code and which bits go where
    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [2:0]       rsh;
        logic [5:0]       fmask;
        logic [2:0]       lsh;
        logic             last;
    } step_t;

    function automatic logic [2:0] eff_width(input logic [2:0] w);
        return (w < CW_2) ? CW_2 : w;
    endfunction

    function automatic logic [6:0] width_mask(input logic [2:0] w);
        return 7'((8'd1 << w) - 8'd1);
    endfunction

    function automatic logic [5:0] burst_len(input logic [2:0] w);
        logic [5:0] len;
        case (w)
            CW_3:    len = 6'd24;
            CW_4:    len = 6'd8;
            CW_5:    len = 6'd40;
            CW_6:    len = 6'd48;
            CW_7:    len = 6'd56;
            default: len = 6'd16;
        endcase
        return len;
    endfunction

    // First byte of the top-bit word at the odd widths
    function automatic logic [5:0] top_base(input logic [2:0] w);
        logic [5:0] base;
        case (w)
            CW_3:    base = 6'd16;
            CW_5:    base = 6'd32;
            default: base = 6'd48;
        endcase
        return base;
    endfunction

    function automatic step_t step_info(input logic [2:0] w, input logic [5:0] b,
                                        input logic [2:0] s);
        step_t      si;
        logic [5:0] t;
        logic       top;
        si  = '0;
        top = ((w == CW_3) || (w == CW_5) || (w == CW_7)) && (b >= top_base(w));
        t   = b - top_base(w);
        if (top) begin
            // one top bit of each of eight codes
            si.addr  = {t[2:0], s};
            si.rsh   = w - 3'd1;
            si.fmask = 6'd1;
            si.lsh   = s;
            si.last  = (s == 3'd7);
        end else begin
            case (w)
                CW_4:
                begin
                    si.addr  = {2'b00, s[0], b[2:0]};
                    si.fmask = 6'd15;
                    si.lsh   = s[0] ? 3'd4 : 3'd0;
                    si.last  = s[0];
                end
                CW_5:
                begin
                    si.addr  = {b[4], s[0], b[3:0]};
                    si.fmask = 6'd15;
                    si.lsh   = s[0] ? 3'd4 : 3'd0;
                    si.last  = s[0];
                end
                CW_6, CW_7:
                begin
                    if (s[0]) begin
                        si.addr  = {2'b11, b[3:0]};
                        si.rsh   = {b[5:4], 1'b0};
                        si.fmask = 6'd3;
                        si.lsh   = 3'd6;
                        si.last  = 1'b1;
                    end else begin
                        si.addr  = b;
                        si.fmask = 6'd63;
                    end
                end
                default:
                begin
                    si.addr  = {s[1:0], b[3:0]};
                    si.fmask = 6'd3;
                    si.lsh   = {s[1:0], 1'b0};
                    si.last  = (s[1:0] == 2'd3);
                end
            endcase
        end
        return si;
    endfunction

endpackage

@@ sv/quantized_code_bit_packer.sv @@
// Top level of the quantized code bit packer: sequencer, shared bit merge unit
// and output register. Depends on qcbp_pkg and qcbp_code_mem.
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tdata[6:0] code, s_tlast last code
// m_*       out  m_tvalid / m_tready       m_tdata byte, m_tlast end of group,
//                                          m_tuser end of vector
// cfg_*     in   cfg_valid / cfg_ready     cfg_data code width
//
// A code that does not close a group is stored and leaves the input open.
// A closing code starts a burst; each byte is built by reading its codes one at a time
// through the single read port of the store, then folding in the last read in ST_LAST.
// Input is held off until the burst is fully built; output stalls pause the build.
// Reset is asynchronous, active low; code width resets to 4, the store is not cleared.
module quantized_code_bit_packer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [6:0] code, [7] zero pad
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] packed_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser,   // [0] last_of_vector
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);
    import qcbp_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]       cw_reg;
    logic [AddrW-1:0] fill_reg, fill_next;
    logic [6:0]       neff_reg, neff_next;
    logic             vend_reg, vend_next;
    logic [2:0]       width_reg, width_next;
    logic [5:0]       byte_reg, byte_next;
    logic [2:0]       step_reg, step_next;
    logic [7:0]       acc_reg, acc_next;

    // Control of the read in flight
    logic [2:0]       p_rsh_reg, p_rsh_next;
    logic [5:0]       p_fmask_reg, p_fmask_next;
    logic [2:0]       p_lsh_reg, p_lsh_next;
    logic             p_hit_reg, p_hit_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_vec_reg, out_vec_next;

    logic             s_accept;
    logic             out_free;
    logic [2:0]       cur_w;
    logic [6:0]       size;
    logic [6:0]       n_new;
    logic             flush;
    logic             last_byte;
    step_t            info;
    logic             mem_we;
    logic             rd_en;
    logic [CodeW-1:0] rd_data;
    logic [CodeW-1:0] masked;
    logic [CodeW-1:0] shifted;
    logic [5:0]       field;
    logic [7:0]       contrib;

    qcbp_code_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (fill_reg),
        .wr_data (s_tdata[CodeW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (info.addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Group closing test on the incoming code
    assign cur_w = eff_width(cw_reg);
    assign size  = (cur_w == CW_4) ? 7'd16 : 7'd64;
    assign n_new = {1'b0, fill_reg} + 7'd1;
    assign flush = (n_new >= size) || s_tlast;

    assign info      = step_info(width_reg, byte_reg, step_reg);
    assign last_byte = (byte_reg == burst_len(width_reg) - 6'd1);

    // Shared merge unit: pick the field of the returned code and place it
    assign masked  = rd_data & width_mask(width_reg);
    assign shifted = masked >> p_rsh_reg;
    assign field   = shifted[5:0] & p_fmask_reg;
    assign contrib = p_hit_reg ? 8'({2'b00, field} << p_lsh_reg) : 8'd0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && flush) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (info.last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (out_free) begin
                    state_next = last_byte ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        fill_next      = fill_reg;
        neff_next      = neff_reg;
        vend_next      = vend_reg;
        width_next     = width_reg;
        byte_next      = byte_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        p_rsh_next     = p_rsh_reg;
        p_fmask_next   = p_fmask_reg;
        p_lsh_next     = p_lsh_reg;
        p_hit_next     = p_hit_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_vec_next   = out_vec_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        // Drop the output word once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept) begin
                    mem_we = 1'b1;
                    if (flush) begin
                        fill_next  = '0;
                        neff_next  = (n_new < size) ? n_new : size;
                        vend_next  = s_tlast;
                        width_next = cur_w;
                        byte_next  = '0;
                        step_next  = '0;
                    end else begin
                        fill_next = n_new[AddrW-1:0];
                    end
                end
            end
            ST_READ:
            begin
                // Issue one code read, fold in the previous one
                rd_en        = 1'b1;
                p_rsh_next   = info.rsh;
                p_fmask_next = info.fmask;
                p_lsh_next   = info.lsh;
                p_hit_next   = ({1'b0, info.addr} < neff_reg);
                acc_next     = (step_reg == 3'd0) ? 8'd0 : (acc_reg | contrib);
                step_next    = step_reg + 3'd1;
            end
            ST_LAST:
            begin
                // Fold in the final read and hand the byte out
                if (out_free) begin
                    out_data_next  = acc_reg | contrib;
                    out_last_next  = last_byte;
                    out_vec_next   = last_byte && vend_reg;
                    out_valid_next = 1'b1;
                    byte_next      = byte_reg + 6'd1;
                    step_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cw_reg        <= CW_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                cw_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        neff_reg     <= neff_next;
        vend_reg     <= vend_next;
        width_reg    <= width_next;
        byte_reg     <= byte_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        p_rsh_reg    <= p_rsh_next;
        p_fmask_reg  <= p_fmask_next;
        p_lsh_reg    <= p_lsh_next;
        p_hit_reg    <= p_hit_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_vec_reg  <= out_vec_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_vec_reg;

endmodule

@@ sv/qcbp_code_mem.sv @@
// Code store of the packer: one write port, one registered read port.
// Depends on qcbp_pkg for depth and code width.
module qcbp_code_mem (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [qcbp_pkg::AddrW-1:0] wr_addr,
    input  logic [qcbp_pkg::CodeW-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [qcbp_pkg::AddrW-1:0] rd_addr,
    output logic [qcbp_pkg::CodeW-1:0] rd_data
);
    import qcbp_pkg::*;

    logic [CodeW-1:0] mem [GroupSize];
    logic [CodeW-1:0] rd_data_reg;

    // Write incoming codes
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/qcbp_checker.sv @@
// Port-level checks of the quantized code bit packer, bound to the top level.
// Depends on quantized_code_bit_packer_assert.svh for the assertion macros.
`include "quantized_code_bit_packer_assert.svh"

module qcbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // End of vector only on the closing word of a group
    `QCBP_ASSERT_SAME(a_vec_in_group, m_tvalid && m_tuser[0], m_tlast, "end of vector without end of group")

    // A pending word inside a burst means input is held off
    `QCBP_ASSERT_SAME(a_busy_in_burst, m_tvalid && !m_tlast, !s_tready, "input open mid burst")

    // A last code always starts a burst
    `QCBP_ASSERT_NEXT(a_flush_blocks, s_tvalid && s_tready && s_tlast, !s_tready, "last code did not flush")

    // Stalled output word holds
    `QCBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

endmodule

bind quantized_code_bit_packer qcbp_checker u_qcbp_checker (.*);

@@ test/quantized_code_bit_packer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the quantized code bit packer: a directed table, then random
// vectors of codes at changing code widths, with a byte-level packing predictor.
// Depends on qcbp_pkg and the quantized_code_bit_packer RTL.
module quantized_code_bit_packer_tb;
    import qcbp_pkg::*;

    localparam int QuietLimit  = 5000;
    localparam int SettleGap   = 16;
    localparam int RandomCodes = 115;
    localparam int IdlePct     = 26;

    // One word expected on the packed byte stream
    typedef struct packed {
        logic [7:0] data;
        logic       grp_end;
        logic       vec_end;
    } packed_word_t;

    // One line of the directed table: optional width write, then count copies of code
    typedef struct packed {
        logic       set_cw;
        logic [2:0] cw;
        logic [6:0] code;
        logic       last;
        logic [5:0] count;
        logic       known;     // burst typed in: first byte, zeros after, given length
        logic [7:0] k_byte0;
        logic [5:0] k_len;
    } plan_row_t;

    localparam int PlanRows = 14;
    localparam plan_row_t PLAN [PlanRows] = '{
        // after reset, width 4
        '{1'b0, CW_4, 7'h7F, 1'b1, 6'd1,  1'b1, 8'h0F, 6'd8},
        '{1'b1, CW_2, 7'h7F, 1'b1, 6'd1,  1'b1, 8'h03, 6'd16},
        '{1'b1, CW_6, 7'h7F, 1'b1, 6'd1,  1'b1, 8'h3F, 6'd48},
        // width below range acts as width 2
        '{1'b1, 3'd0, 7'h7F, 1'b1, 6'd1,  1'b1, 8'h03, 6'd16},
        // odd widths carry the top-bit word
        '{1'b1, CW_3, 7'h7F, 1'b1, 6'd1,  1'b0, 8'h00, 6'd0},
        '{1'b1, CW_5, 7'h7F, 1'b1, 6'd1,  1'b0, 8'h00, 6'd0},
        '{1'b1, CW_7, 7'h7F, 1'b1, 6'd1,  1'b0, 8'h00, 6'd0},
        // partial group of three, padded with zeros
        '{1'b0, CW_7, 7'h55, 1'b0, 6'd1,  1'b0, 8'h00, 6'd0},
        '{1'b0, CW_7, 7'h2A, 1'b0, 6'd1,  1'b0, 8'h00, 6'd0},
        '{1'b0, CW_7, 7'h7F, 1'b1, 6'd1,  1'b0, 8'h00, 6'd0},
        // width change mid-group: held codes reach the smaller group size
        '{1'b1, CW_2, 7'h6C, 1'b0, 6'd15, 1'b0, 8'h00, 6'd0},
        '{1'b1, CW_4, 7'h13, 1'b0, 6'd1,  1'b0, 8'h00, 6'd0},
        // width change mid-group below the group size
        '{1'b1, CW_5, 7'h40, 1'b0, 6'd1,  1'b0, 8'h00, 6'd0},
        '{1'b1, CW_6, 7'h01, 1'b1, 6'd1,  1'b0, 8'h00, 6'd0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [6:0] code, [7] zero pad
    logic       s_tlast = 1'b0;     // last code of the vector
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] packed byte
    logic       m_tlast;            // last byte of the group
    logic [0:0] m_tuser;            // [0] last byte of the vector
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data = CW_RESET;

    // Predictor state
    logic [6:0]   held [GroupSize];
    int           held_n = 0;
    logic [2:0]   width_reg = CW_RESET;
    packed_word_t words_due [$];

    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           codes_sent = 0;
    bit           steady = 1'b0;
    packed_word_t want;

    quantized_code_bit_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int active_width(input logic [2:0] w);
        return (w < 3'd2) ? 2 : int'(w);
    endfunction

    // Held code i of a group of n, masked to the width; zero past the fill
    function automatic int code_of(input int i, input int n, input int w);
        if (i >= n)
            return 0;
        return int'(held[i]) & ((1 << w) - 1);
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < IdlePct);
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < 40)
            $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Store one code; on a closed group, build its burst and queue the words
    task automatic pack_code(input logic [6:0] code, input logic last, input bit record);
        int           w;
        int           size;
        int           n;
        int           len;
        int           j;
        int           k;
        int           b;
        logic [7:0]   burst [56];
        packed_word_t pw;
        w    = active_width(width_reg);
        size = (w == 4) ? 16 : GroupSize;
        held[held_n] = code;
        n = held_n + 1;
        if (n < size && !last) begin
            held_n = n;
            return;
        end
        held_n = 0;
        if (n > size)
            n = size;
        len = 0;
        if (w == 4) begin
            for (j = 0; j < 8; j++) begin
                burst[len] = 8'(code_of(j, n, w) | (code_of(8 + j, n, w) << 4));
                len++;
            end
        end else if (w == 2 || w == 3) begin
            for (j = 0; j < 16; j++) begin
                b = 0;
                for (k = 0; k < 4; k++)
                    b |= (code_of(k * 16 + j, n, w) & 3) << (2 * k);
                burst[len] = 8'(b);
                len++;
            end
        end else if (w == 5) begin
            for (k = 0; k < 2; k++)
                for (j = 0; j < 16; j++) begin
                    burst[len] = 8'((code_of(k * 32 + j, n, w) & 15) |
                                    ((code_of(k * 32 + 16 + j, n, w) & 15) << 4));
                    len++;
                end
        end else begin
            for (k = 0; k < 3; k++)
                for (j = 0; j < 16; j++) begin
                    burst[len] = 8'((code_of(k * 16 + j, n, w) & 63) |
                                    (((code_of(48 + j, n, w) >> (2 * k)) & 3) << 6));
                    len++;
                end
        end
        // append the top-bit word, low byte first
        if (w == 3 || w == 5 || w == 7) begin
            for (k = 0; k < 8; k++) begin
                b = 0;
                for (j = 0; j < 8; j++)
                    b |= ((code_of(k * 8 + j, n, w) >> (w - 1)) & 1) << j;
                burst[len] = 8'(b);
                len++;
            end
        end
        if (record) begin
            for (j = 0; j < len; j++) begin
                pw.data    = burst[j];
                pw.grp_end = (j == len - 1);
                pw.vec_end = (j == len - 1) && last;
                words_due.push_back(pw);
            end
        end
    endtask

    // Offer one code word, wait for it to be taken, then predict
    task automatic send_code(input logic [6:0] code, input logic last, input bit record);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, code};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pack_code(code, last, record);
        codes_sent++;
    endtask

    // Drop input and wait until every queued byte is out and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SettleGap) @(posedge clk);
    endtask

    task automatic write_width(input logic [2:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // Check each accepted byte word, drive the output stalls, count quiet cycles
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (m_tvalid && m_tready) begin
                    if (words_due.size() == 0) begin
                        flag_mismatch($sformatf("byte %02h with nothing expected", m_tdata));
                    end else begin
                        want = words_due.pop_front();
                        if (m_tdata !== want.data)
                            flag_mismatch($sformatf("packed byte %02h, expected %02h",
                                                    m_tdata, want.data));
                        if (m_tlast !== want.grp_end)
                            flag_mismatch($sformatf("group end %b, expected %b",
                                                    m_tlast, want.grp_end));
                        if (m_tuser[0] !== want.vec_end)
                            flag_mismatch($sformatf("vector end %b, expected %b",
                                                    m_tuser[0], want.vec_end));
                    end
                end
                if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                    (cfg_valid && cfg_ready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                m_tready <= !take_break();
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QuietLimit)
            @(posedge clk);
        $display("quantized_code_bit_packer: mismatch");
        $finish;
    end

    initial
    begin
        plan_row_t row;
        int        r;
        int        c;
        int        j;
        int        phase;
        int        first_random;
        int        size;
        int        vectors;
        int        v;
        int        len;
        int        pick;
        int        tail;
        logic [2:0] cw;
        packed_word_t pw;

        // hold reset low, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (r = 0; r < PlanRows; r++) begin
            row = PLAN[r];
            if (row.set_cw) begin
                settle();
                write_width(row.cw);
            end
            for (c = 0; c < int'(row.count); c++)
                send_code(row.code, row.last && (c == int'(row.count) - 1), !row.known);
            if (row.known) begin
                for (j = 0; j < int'(row.k_len); j++) begin
                    pw.data    = (j == 0) ? row.k_byte0 : 8'h00;
                    pw.grp_end = (j == int'(row.k_len) - 1);
                    pw.vec_end = (j == int'(row.k_len) - 1);
                    words_due.push_back(pw);
                end
            end
        end

        // random vectors; the first phases take the extreme widths
        first_random = codes_sent;
        phase = 0;
        while (codes_sent < first_random + RandomCodes) begin
            if (phase == 0)
                cw = CW_2;
            else if (phase == 1)
                cw = CW_7;
            else
                cw = 3'($urandom_range(0, 7));
            settle();
            write_width(cw);
            steady = (phase == 0);
            size = (active_width(cw) == 4) ? 16 : GroupSize;
            vectors = $urandom_range(1, 2);
            for (v = 0; v < vectors; v++) begin
                pick = $urandom_range(0, 4);
                if (pick == 0)
                    len = size;
                else if (pick == 1)
                    len = size + $urandom_range(1, 8);
                else
                    len = $urandom_range(1, size / 4 + 2);
                for (c = 0; c < len; c++)
                    send_code(7'($urandom_range(0, 127)), c == len - 1, 1'b1);
            end
            // leave a broken vector open across the next width change
            if ($urandom_range(0, 2) == 0) begin
                tail = $urandom_range(1, 24);
                for (c = 0; c < tail; c++)
                    send_code(7'($urandom_range(0, 127)), 1'b0, 1'b1);
            end
            steady = 1'b0;
            phase++;
        end

        // drain and let the block go quiet
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (4 * SettleGap) @(posedge clk);

        if (mismatches == 0 && words_due.size() == 0)
            $display("quantized_code_bit_packer: match");
        else
            $display("quantized_code_bit_packer: mismatch");
        $finish;
    end

endmodule

@@ quantized_code_bit_packer.f @@
+incdir+sv
sv/qcbp_pkg.sv
sv/qcbp_code_mem.sv
sv/quantized_code_bit_packer.sv
sv/qcbp_checker.sv
test/quantized_code_bit_packer_tb.sv
